@@ rtl/core/tgr_pkg.sv @@
// ----------------------------------------------------------------------------
// tgr_pkg: shared definitions for the text glyph rasterizer
// Font geometry, derived widths, register indexes and status codes.
// ----------------------------------------------------------------------------
package tgr_pkg;

    // Font geometry
    localparam int CHAR_WIDTH       = 5;
    localparam int CHAR_HEIGHT      = 8;
    localparam int BYTES_PER_COLUMN = 1;
    localparam int FIRST_CODE       = 32;
    localparam int LAST_CODE        = 126;
    localparam int FONT_BYTES       = 512;

    // Field widths
    localparam int COORD_W   = 12;
    localparam int BOX_W     = 11;
    localparam int GAP_W     = 6;
    localparam int CODE_W    = 8;
    localparam int FADDR_W   = 9;
    localparam int FBYTE_W   = 8;
    localparam int CFG_IDX_W = 3;

    // Derived widths
    localparam int FONT_AW = (FONT_BYTES > 1) ? $clog2(FONT_BYTES) : 1;
    // byte address of a glyph scan, wide enough for any code in range
    localparam int SCAN_AW = $clog2(257 * BYTES_PER_COLUMN * CHAR_WIDTH + 2);
    localparam int COL_W   = (CHAR_WIDTH > 1) ? $clog2(CHAR_WIDTH) : 1;
    localparam int ROW_W   = ($clog2(CHAR_HEIGHT) > 3) ? $clog2(CHAR_HEIGHT) : 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_LEFT   = 3'd0,
        CFG_BOX_TOP    = 3'd1,
        CFG_BOX_RIGHT  = 3'd2,
        CFG_BOX_BOTTOM = 3'd3,
        CFG_LINE_GAP   = 3'd4,
        CFG_CHAR_GAP   = 3'd5,
        CFG_PEN_COLOR  = 3'd6
    } cfg_idx_t;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_BAD_BOX = 2'd1,
        STATUS_STOPPED = 2'd2
    } status_t;

endpackage

@@ rtl/core/tgr_ram.sv @@
// ----------------------------------------------------------------------------
// tgr_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents have no reset.
// ----------------------------------------------------------------------------
module tgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/text_glyph_rasterizer_unit.sv @@
// ----------------------------------------------------------------------------
// text_glyph_rasterizer_unit: bitmap font character generator
// Font loads fill a column-major glyph RAM; characters are laid out in a box
// and every set glyph bit is sent out as one pixel write word.
// ----------------------------------------------------------------------------
// A font load is written at acceptance, one load per cycle while the unit is idle.
// A character: setup in the check, place and limit states, then per glyph
// column one RAM read in the address state and one scan step per row bit,
// then a finish step that sends the final word; the next word is taken in idle.
// Status-only results (bad box, stopped) come from the check or limit state.
// Reset clears cursor, stop flag and handshakes and sets configuration defaults; glyph RAM is not.
module text_glyph_rasterizer_unit
    import tgr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,

    // configuration write port
    input  logic                       cfg_we,
    input  logic [CFG_IDX_W-1:0]       cfg_index,
    input  logic [BOX_W-1:0]           cfg_data,

    // input words
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       req_type,
    input  logic                       first_of_string,
    input  logic [CODE_W-1:0]          char_code,
    input  logic [FADDR_W-1:0]         font_addr,
    input  logic [FBYTE_W-1:0]         font_byte,

    // result words
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       pixel_valid,
    output logic signed [COORD_W-1:0]  pixel_x,
    output logic signed [COORD_W-1:0]  pixel_y,
    output logic                       pixel_color,
    output logic [1:0]                 status,
    output logic                       last
);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_PLACE  = 6'b000100,
        S_LIMIT  = 6'b001000,
        S_ADDR   = 6'b010000,
        S_SCAN   = 6'b100000
    } state_t;

    // finish is folded in as a flag on scan exit or for an out-of-range code; see fin_reg
    state_t state_reg, state_next;
    logic   fin_reg, fin_next;

    // configuration registers
    logic [BOX_W-1:0] box_left_reg, box_left_next;
    logic [BOX_W-1:0] box_top_reg, box_top_next;
    logic [BOX_W-1:0] box_right_reg, box_right_next;
    logic [BOX_W-1:0] box_bottom_reg, box_bottom_next;
    logic [GAP_W-1:0] line_gap_reg, line_gap_next;
    logic [GAP_W-1:0] char_gap_reg, char_gap_next;
    logic             pen_color_reg, pen_color_next;

    // layout state
    logic [COORD_W-1:0] cursor_x_reg, cursor_x_next;
    logic [COORD_W-1:0] cursor_y_reg, cursor_y_next;
    logic               stopped_reg, stopped_next;

    // current character
    logic               first_reg, first_next;
    logic [CODE_W-1:0]  code_reg, code_next;
    logic [SCAN_AW-1:0] base_reg, base_next;

    // scan counters
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [SCAN_AW-1:0] col_base_reg, col_base_next;
    logic               in_range_reg, in_range_next;

    // pixel held back until we know whether it is the last one
    logic               pend_valid_reg, pend_valid_next;
    logic [COORD_W-1:0] pend_x_reg, pend_x_next;
    logic [COORD_W-1:0] pend_y_reg, pend_y_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic               out_pix_reg, out_pix_next;
    logic [COORD_W-1:0] out_x_reg, out_x_next;
    logic [COORD_W-1:0] out_y_reg, out_y_next;
    logic               out_color_reg, out_color_next;
    status_t            out_status_reg, out_status_next;
    logic               out_last_reg, out_last_next;

    // RAM interface
    logic               ram_we;
    logic [FONT_AW-1:0] ram_waddr;
    logic               ram_re;
    logic [FONT_AW-1:0] ram_raddr;
    logic [FBYTE_W-1:0] ram_rdata;
    logic [SCAN_AW-1:0] rd_addr;

    // push request into the output register
    logic               push;
    logic               push_pix;
    logic [COORD_W-1:0] push_x;
    logic [COORD_W-1:0] push_y;
    status_t            push_status;
    logic               push_last;

    logic               out_free;
    logic               box_bad;
    logic               code_ok;
    logic               wrap_x;
    logic               below;
    logic               glyph_bit;
    logic               last_row;
    logic               last_col;
    logic [COORD_W-1:0] new_x;
    logic [COORD_W-1:0] new_y;
    logic signed [COORD_W+1:0] cx_far;
    logic signed [COORD_W+1:0] cy_far;
    logic signed [COORD_W+1:0] right_ext;
    logic signed [COORD_W+1:0] bottom_ext;

    // glyph store
    tgr_ram #(
        .WIDTH (FBYTE_W),
        .DEPTH (FONT_BYTES)
    ) u_glyph_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (font_byte),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // font loads write straight from the input word
    assign ram_we    = in_valid && in_ready && !req_type
                       && (32'(font_addr) < 32'(FONT_BYTES));
    assign ram_waddr = FONT_AW'(font_addr);

    // glyph byte address: column base plus row byte
    assign rd_addr   = col_base_reg + SCAN_AW'(row_reg >> 3);
    assign ram_raddr = FONT_AW'(rd_addr);

    // layout arithmetic
    assign out_free   = !out_valid_reg || out_ready;
    assign box_bad    = ($signed(box_right_reg) < $signed(box_left_reg))
                        || ($signed(box_bottom_reg) < $signed(box_top_reg));
    assign code_ok    = (32'(code_reg) >= 32'(FIRST_CODE))
                        && (32'(code_reg) <= 32'(LAST_CODE));
    assign cx_far     = $signed({{2{cursor_x_reg[COORD_W-1]}}, cursor_x_reg})
                        + $signed((COORD_W+2)'(CHAR_WIDTH));
    assign cy_far     = $signed({{2{cursor_y_reg[COORD_W-1]}}, cursor_y_reg})
                        + $signed((COORD_W+2)'(CHAR_HEIGHT));
    assign right_ext  = $signed({{3{box_right_reg[BOX_W-1]}}, box_right_reg});
    assign bottom_ext = $signed({{3{box_bottom_reg[BOX_W-1]}}, box_bottom_reg});
    assign wrap_x     = cx_far > right_ext;
    assign below      = cy_far > bottom_ext;

    // scan position
    assign glyph_bit = ram_rdata[row_reg[2:0]] && in_range_reg;
    assign last_row  = (row_reg == ROW_W'(CHAR_HEIGHT - 1));
    assign last_col  = (col_reg == COL_W'(CHAR_WIDTH - 1));
    assign new_x     = cursor_x_reg + COORD_W'(col_reg);
    assign new_y     = cursor_y_reg + COORD_W'(row_reg);

    // sequencer and datapath next state
    always_comb
    begin
        state_next      = state_reg;
        fin_next        = fin_reg;
        box_left_next   = box_left_reg;
        box_top_next    = box_top_reg;
        box_right_next  = box_right_reg;
        box_bottom_next = box_bottom_reg;
        line_gap_next   = line_gap_reg;
        char_gap_next   = char_gap_reg;
        pen_color_next  = pen_color_reg;
        cursor_x_next   = cursor_x_reg;
        cursor_y_next   = cursor_y_reg;
        stopped_next    = stopped_reg;
        first_next      = first_reg;
        code_next       = code_reg;
        base_next       = base_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        col_base_next   = col_base_reg;
        in_range_next   = in_range_reg;
        pend_valid_next = pend_valid_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        ram_re          = 1'b0;
        in_ready        = 1'b0;
        push            = 1'b0;
        push_pix        = 1'b0;
        push_x          = '0;
        push_y          = '0;
        push_status     = STATUS_OK;
        push_last       = 1'b0;

        // register writes
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_BOX_LEFT:   box_left_next   = cfg_data;
                CFG_BOX_TOP:    box_top_next    = cfg_data;
                CFG_BOX_RIGHT:  box_right_next  = cfg_data;
                CFG_BOX_BOTTOM: box_bottom_next = cfg_data;
                CFG_LINE_GAP:   line_gap_next   = cfg_data[GAP_W-1:0];
                CFG_CHAR_GAP:   char_gap_next   = cfg_data[GAP_W-1:0];
                CFG_PEN_COLOR:  pen_color_next  = cfg_data[0];
                default:        ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && req_type)
                begin
                    first_next = first_of_string;
                    code_next  = char_code;
                    state_next = S_CHECK;
                end
            end

            // box sanity, string start, stop flag; glyph base address
            S_CHECK:
            begin
                base_next = SCAN_AW'((SCAN_AW'(code_reg) - SCAN_AW'(FIRST_CODE))
                            * SCAN_AW'(BYTES_PER_COLUMN * CHAR_WIDTH));
                if (out_free)
                begin
                    if (box_bad)
                    begin
                        push        = 1'b1;
                        push_status = STATUS_BAD_BOX;
                        push_last   = 1'b1;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        if (first_reg)
                        begin
                            cursor_x_next = {box_left_reg[BOX_W-1], box_left_reg};
                            cursor_y_next = {box_top_reg[BOX_W-1], box_top_reg};
                            stopped_next  = 1'b0;
                        end
                        if (!first_reg && stopped_reg)
                        begin
                            push        = 1'b1;
                            push_status = STATUS_STOPPED;
                            push_last   = 1'b1;
                            state_next  = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_PLACE;
                        end
                    end
                end
            end

            // line wrap at the right edge
            S_PLACE:
            begin
                if (wrap_x)
                begin
                    cursor_x_next = {box_left_reg[BOX_W-1], box_left_reg};
                    cursor_y_next = cursor_y_reg + COORD_W'(CHAR_HEIGHT)
                                    + COORD_W'(line_gap_reg);
                end
                state_next = S_LIMIT;
            end

            // bottom edge stop, else start the glyph scan
            S_LIMIT:
            begin
                if (below)
                begin
                    if (out_free)
                    begin
                        stopped_next = 1'b1;
                        push         = 1'b1;
                        push_status  = STATUS_STOPPED;
                        push_last    = 1'b1;
                        state_next   = S_IDLE;
                    end
                end
                else
                begin
                    col_next      = '0;
                    row_next      = '0;
                    col_base_next = base_reg;
                    fin_next      = !code_ok;
                    state_next    = S_ADDR;
                end
            end

            // read one glyph byte, or finish the character
            S_ADDR:
            begin
                if (fin_reg)
                begin
                    if (out_free)
                    begin
                        push      = 1'b1;
                        push_last = 1'b1;
                        if (pend_valid_reg)
                        begin
                            push_pix = 1'b1;
                            push_x   = pend_x_reg;
                            push_y   = pend_y_reg;
                        end
                        pend_valid_next = 1'b0;
                        fin_next        = 1'b0;
                        cursor_x_next   = cursor_x_reg + COORD_W'(CHAR_WIDTH)
                                          + COORD_W'(char_gap_reg);
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    ram_re        = 1'b1;
                    in_range_next = (32'(rd_addr) < 32'(FONT_BYTES));
                    state_next    = S_SCAN;
                end
            end

            // one glyph bit per cycle unless the output stalls, columns outer, rows inner
            S_SCAN:
            begin
                if (!glyph_bit || !pend_valid_reg || out_free)
                begin
                    if (glyph_bit)
                    begin
                        if (pend_valid_reg)
                        begin
                            push     = 1'b1;
                            push_pix = 1'b1;
                            push_x   = pend_x_reg;
                            push_y   = pend_y_reg;
                        end
                        pend_valid_next = 1'b1;
                        pend_x_next     = new_x;
                        pend_y_next     = new_y;
                    end
                    if (last_row)
                    begin
                        row_next = '0;
                        if (last_col)
                        begin
                            fin_next = 1'b1;
                        end
                        else
                        begin
                            col_next      = col_reg + COL_W'(1);
                            col_base_next = col_base_reg + SCAN_AW'(BYTES_PER_COLUMN);
                        end
                        state_next = S_ADDR;
                    end
                    else
                    begin
                        row_next = row_reg + ROW_W'(1);
                        // next row starts a new byte
                        if (row_next[2:0] == 3'd0)
                        begin
                            state_next = S_ADDR;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // output register
        out_valid_next  = push || (out_valid_reg && !out_ready);
        out_pix_next    = out_pix_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_color_next  = out_color_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        if (push)
        begin
            out_pix_next    = push_pix;
            out_x_next      = push_x;
            out_y_next      = push_y;
            out_color_next  = push_pix && pen_color_reg;
            out_status_next = push_status;
            out_last_next   = push_last;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fin_reg        <= 1'b0;
            box_left_reg   <= BOX_W'(0);
            box_top_reg    <= BOX_W'(0);
            box_right_reg  <= BOX_W'(127);
            box_bottom_reg <= BOX_W'(63);
            line_gap_reg   <= GAP_W'(0);
            char_gap_reg   <= GAP_W'(1);
            pen_color_reg  <= 1'b1;
            cursor_x_reg   <= '0;
            cursor_y_reg   <= '0;
            stopped_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fin_reg        <= fin_next;
            box_left_reg   <= box_left_next;
            box_top_reg    <= box_top_next;
            box_right_reg  <= box_right_next;
            box_bottom_reg <= box_bottom_next;
            line_gap_reg   <= line_gap_next;
            char_gap_reg   <= char_gap_next;
            pen_color_reg  <= pen_color_next;
            cursor_x_reg   <= cursor_x_next;
            cursor_y_reg   <= cursor_y_next;
            stopped_reg    <= stopped_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        first_reg      <= first_next;
        code_reg       <= code_next;
        base_reg       <= base_next;
        col_reg        <= col_next;
        row_reg        <= row_next;
        col_base_reg   <= col_base_next;
        in_range_reg   <= in_range_next;
        pend_x_reg     <= pend_x_next;
        pend_y_reg     <= pend_y_next;
        out_pix_reg    <= out_pix_next;
        out_x_reg      <= out_x_next;
        out_y_reg      <= out_y_next;
        out_color_reg  <= out_color_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    // ports
    assign out_valid   = out_valid_reg;
    assign pixel_valid = out_pix_reg;
    assign pixel_x     = $signed(out_x_reg);
    assign pixel_y     = $signed(out_y_reg);
    assign pixel_color = out_color_reg;
    assign status      = out_status_reg;
    assign last        = out_last_reg;

endmodule

@@ rtl/core/tgr_checker.sv @@
// ----------------------------------------------------------------------------
// tgr_checker: port-level checks for the text glyph rasterizer
// Watches the handshakes and result words; attached by bind.
// ----------------------------------------------------------------------------
module tgr_checker
    import tgr_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       req_type,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       pixel_valid,
    input  logic signed [COORD_W-1:0]  pixel_x,
    input  logic signed [COORD_W-1:0]  pixel_y,
    input  logic [1:0]                 status,
    input  logic                       last
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
                                    && $stable(status) && $stable(last))
        else $error("result word changed while stalled");

    // a character word blocks the input while it is drawn
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type |=> !in_ready)
        else $error("input taken while a character is in work");

    // pixel writes only carry ok status
    a_pix_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pixel_valid |-> status == STATUS_OK)
        else $error("pixel write with error status");

    // every non-pixel word closes its character
    a_nopix_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !pixel_valid |-> last && pixel_x == '0 && pixel_y == '0)
        else $error("non-pixel word not final or not cleared");

    // no undefined status code
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == STATUS_OK || status == STATUS_BAD_BOX
                      || status == STATUS_STOPPED)
        else $error("undefined status code");

endmodule

bind text_glyph_rasterizer_unit tgr_checker u_tgr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_valid (pixel_valid),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .status      (status),
    .last        (last)
);
